@@ hdl/particle_pool_update_macros.svh @@
// assertion macros for the particle pool update block
`ifndef PARTICLE_POOL_UPDATE_MACROS_SVH
`define PARTICLE_POOL_UPDATE_MACROS_SVH
`define PPU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PPU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`endif

@@ hdl/ppu_pkg.sv @@
// shared types and constants for the particle pool update block
package ppu_pkg;
  localparam int unsigned NumRegs = 7;
  localparam logic [2:0] RegGravX  = 3'd0;
  localparam logic [2:0] RegGravY  = 3'd1;
  localparam logic [2:0] RegGravZ  = 3'd2;
  localparam logic [2:0] RegSizeS  = 3'd3;
  localparam logic [2:0] RegSizeE  = 3'd4;
  localparam logic [2:0] RegColS   = 3'd5;
  localparam logic [2:0] RegColE   = 3'd6;
  localparam logic OpTick  = 1'b0;
  localparam logic OpSpawn = 1'b1;
  localparam logic [16:0] OneQ16 = 17'h10000;

  typedef struct packed {
    logic        opcode;
    logic [15:0] time_step;
    logic [31:0] spawn_x;
    logic [31:0] spawn_y;
    logic [31:0] spawn_z;
    logic [31:0] launch_vx;
    logic [31:0] launch_vy;
    logic [31:0] launch_vz;
    logic [31:0] lifetime;
    logic [31:0] start_angle;
    logic [31:0] spin_rate;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] size_now;
    logic [31:0] angle_now;
    logic [31:0] color_now;
    logic        last;
  } out_item_t;

  // divider control
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] ratio;
  } div_rsp_t;
endpackage

@@ hdl/ppu_if.sv @@
// valid/ready channel carrying a packed payload
interface ppu_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/particle_pool_update.sv @@
// particle pool update, one transaction at a time; in_ready is high only when idle
// spawn: writes the lowest free slot, scanning up from slot 0; a full pool drops it
// tick: walks every slot; a dead slot is skipped, a retiring one is freed, a live one
//   runs the multiply, divide (nonzero lifetime only) and interpolate passes, and
//   output stalls hold the walk; in_ready returns once the last result is in the output register
// reset clears the alive bits and the registers to their defaults; no ram sweep
module particle_pool_update import ppu_pkg::*; #(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppu_if.sink         in_ch,
  ppu_if.source       out_ch,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned Aw = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam logic [Aw-1:0] LastSlot = Aw'(POOL_SIZE - 1);

  localparam logic [3:0] StIdle = 4'd0, StScan = 4'd1, StRead = 4'd2, StRd2 = 4'd3,
                         StMul = 4'd4, StDiv = 4'd5, StLerp = 4'd6, StWrite = 4'd7,
                         StOut = 4'd8, StNext = 4'd9, StLife = 4'd10;

  logic [31:0] grav_q [3];
  logic [31:0] size_s_q, size_e_q, col_s_q, col_e_q;
  logic [POOL_SIZE-1:0] alive_q;
  logic [3:0] st_q;
  logic [Aw-1:0] idx_q;
  logic [3:0] step_q;
  logic mul_ph_q;
  in_item_t item_q;
  logic [15:0] dt_q;

  // working copy of one particle
  logic [31:0] px_q, py_q, pz_q, vx_q, vy_q, vz_q, ang_q, spn_q, ll_q, lt_q;
  logic [16:0] t_q;
  logic [31:0] size_q, color_q;
  out_item_t out_q;
  logic out_v_q;
  logic have_q;
  out_item_t pend_q;
  logic out_free, out_load;

  assign out_free = !out_v_q || out_ch.ready;
  assign out_load = have_q && out_free &&
                    ((st_q == StOut) || (st_q == StNext && idx_q == LastSlot));

  // ram: one wide word per slot
  localparam int unsigned Rw = 32 * 10;
  logic ram_we;
  logic [Rw-1:0] ram_wd, ram_rd;
  ppu_ram #(.Width(Rw), .Depth(POOL_SIZE)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(idx_q), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );

  // shared multiply unit: signed 33x18 product, registered
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p_q;
  logic [31:0] sc;
  assign sc = mul_p_q[47:16];

  div_req_t dreq;
  div_rsp_t drsp;
  ppu_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // operand select for the shared multiplier
  logic [31:0] lin_s, lin_e;
  always_comb begin
    mul_a = '0; mul_b = {2'b00, dt_q};
    lin_s = '0; lin_e = '0;
    case (step_q)
      4'd0: mul_a = {grav_q[0][31], grav_q[0]};
      4'd1: mul_a = {grav_q[1][31], grav_q[1]};
      4'd2: mul_a = {grav_q[2][31], grav_q[2]};
      4'd3: mul_a = {vx_q[31], vx_q};
      4'd4: mul_a = {vy_q[31], vy_q};
      4'd5: mul_a = {vz_q[31], vz_q};
      4'd6: mul_a = {spn_q[31], spn_q};
      4'd7: begin lin_s = size_s_q; lin_e = size_e_q; end
      4'd8: begin lin_s = {24'd0, col_s_q[7:0]};   lin_e = {24'd0, col_e_q[7:0]};   end
      4'd9: begin lin_s = {24'd0, col_s_q[15:8]};  lin_e = {24'd0, col_e_q[15:8]};  end
      4'd10: begin lin_s = {24'd0, col_s_q[23:16]}; lin_e = {24'd0, col_e_q[23:16]}; end
      4'd11: begin lin_s = {24'd0, col_s_q[31:24]}; lin_e = {24'd0, col_e_q[31:24]}; end
      default: ;
    endcase
    if (step_q >= 4'd7) begin
      mul_a = {1'b0, lin_e} - {1'b0, lin_s};
      mul_b = {1'b0, t_q};
    end
  end

  logic [47:0] lerp_v;
  assign lerp_v = {lin_s, 16'd0} + 48'(mul_p_q[47:0]);

  // lowest free slot is found by walking idx
  assign in_ch.ready = (st_q == StIdle);
  assign out_ch.valid = out_v_q;
  assign out_ch.data  = out_q;

  always_comb begin
    ram_we = 1'b0;
    ram_wd = {px_q, py_q, pz_q, vx_q, vy_q, vz_q, ang_q, spn_q, ll_q, lt_q};
    dreq.start = 1'b0; dreq.dividend = ll_q; dreq.divisor = lt_q;
    if (st_q == StScan && !alive_q[idx_q] && item_q.opcode == OpSpawn) begin
      ram_we = 1'b1;
      ram_wd = {item_q.spawn_x, item_q.spawn_y, item_q.spawn_z, item_q.launch_vx,
                item_q.launch_vy, item_q.launch_vz, item_q.start_angle, item_q.spin_rate,
                item_q.lifetime, item_q.lifetime};
    end
    if (st_q == StWrite) ram_we = 1'b1;
    if (st_q == StMul && step_q == 4'd7 && lt_q != 32'd0) dreq.start = 1'b0;
    if (st_q == StLife) dreq.start = (lt_q != 32'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q[0] <= '0; grav_q[1] <= '0; grav_q[2] <= '0;
      size_s_q <= 32'h10000; size_e_q <= 32'h10000;
      col_s_q <= '1; col_e_q <= '1;
      alive_q <= '0; st_q <= StIdle; idx_q <= '0; step_q <= '0;
      out_v_q <= 1'b0; have_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegGravX: grav_q[0] <= cfg_data_i;
          RegGravY: grav_q[1] <= cfg_data_i;
          RegGravZ: grav_q[2] <= cfg_data_i;
          RegSizeS: size_s_q <= cfg_data_i;
          RegSizeE: size_e_q <= cfg_data_i;
          RegColS:  col_s_q <= cfg_data_i;
          RegColE:  col_e_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) out_v_q <= 1'b1;
      else if (out_ch.ready) out_v_q <= 1'b0;
      case (st_q)
        StIdle: if (in_ch.valid) begin
          idx_q <= '0; have_q <= 1'b0; st_q <= StScan;
        end
        StScan: begin
          if (item_q.opcode == OpSpawn) begin
            if (!alive_q[idx_q]) begin
              alive_q[idx_q] <= 1'b1; st_q <= StIdle;
            end else if (idx_q == LastSlot) st_q <= StIdle;
            else idx_q <= idx_q + Aw'(1);
          end else if (alive_q[idx_q]) st_q <= StRead;
          else st_q <= StNext;
        end
        StRead: st_q <= StRd2;
        StRd2: begin
          if (ram_rd[63:32] <= {16'd0, dt_q}) begin
            alive_q[idx_q] <= 1'b0; st_q <= StNext;
          end else begin
            st_q <= StMul;
          end
        end
        StMul: begin
          // each step first forms the product in mul_p_q, then applies it
          if (step_q == 4'd7) st_q <= StLife;
          else st_q <= StMul;
        end
        StLife: st_q <= (lt_q == 32'd0) ? StLerp : StDiv;
        StDiv: if (drsp.done) st_q <= StLerp;
        StLerp: if (step_q == 4'd12) st_q <= StWrite;
        StWrite: st_q <= StOut;
        StOut: if (out_free) begin
          // hold one finished result back so that last can be marked
          if (have_q) out_q <= pend_q;
          have_q <= 1'b1;
          st_q <= StNext;
        end
        StNext: begin
          if (idx_q == LastSlot) begin
            if (have_q && out_free) begin
              out_q <= {pend_q[$bits(out_item_t)-1:1], 1'b1};
              have_q <= 1'b0; st_q <= StIdle;
            end else if (!have_q) st_q <= StIdle;
          end else begin
            idx_q <= idx_q + Aw'(1); st_q <= StScan;
          end
        end
        default: st_q <= StIdle;
      endcase
      // sub-step sequencing for the multiply and interpolation passes
      if (st_q == StRd2) step_q <= '0;
      if (st_q == StMul || st_q == StLerp) begin
        if (mul_ph_q) step_q <= step_q + 4'd1;
      end
      if (st_q == StLife) step_q <= 4'd7;
      if (st_q == StLerp && step_q == 4'd12) step_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mul_ph_q <= 1'b0;
    else if (st_q == StMul || st_q == StLerp) mul_ph_q <= !mul_ph_q;
    else mul_ph_q <= 1'b0;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      item_q <= in_ch.data; dt_q <= in_ch.data.time_step;
    end
    mul_p_q <= 51'(mul_a * mul_b);
    if (st_q == StRd2) begin
      {px_q, py_q, pz_q, vx_q, vy_q, vz_q, ang_q, spn_q, lt_q} <=
        {ram_rd[319:64], ram_rd[31:0]};
      ll_q <= ram_rd[63:32] - {16'd0, dt_q};
    end
    if (mul_ph_q && st_q == StMul) begin
      case (step_q)
        4'd0: vx_q <= vx_q + sc;
        4'd1: vy_q <= vy_q + sc;
        4'd2: vz_q <= vz_q + sc;
        4'd3: px_q <= px_q + sc;
        4'd4: py_q <= py_q + sc;
        4'd5: pz_q <= pz_q + sc;
        4'd6: ang_q <= ang_q + sc;
        default: ;
      endcase
    end
    if (st_q == StLife && lt_q == 32'd0) t_q <= OneQ16;
    if (st_q == StDiv && drsp.done) t_q <= OneQ16 - drsp.ratio;
    if (mul_ph_q && st_q == StLerp) begin
      case (step_q)
        4'd7:  size_q <= lerp_v[47:16];
        4'd8:  color_q[7:0]   <= lerp_v[23:16];
        4'd9:  color_q[15:8]  <= lerp_v[23:16];
        4'd10: color_q[23:16] <= lerp_v[23:16];
        4'd11: color_q[31:24] <= lerp_v[23:16];
        default: ;
      endcase
    end
    // the previous result moves out before this one is parked
    if (st_q == StOut && out_free) begin
      pend_q.slot <= 6'(idx_q);
      pend_q.pos_x <= px_q; pend_q.pos_y <= py_q; pend_q.pos_z <= pz_q;
      pend_q.size_now <= size_q; pend_q.angle_now <= ang_q;
      pend_q.color_now <= color_q; pend_q.last <= 1'b0;
    end
  end
endmodule

@@ hdl/ppu_ram.sv @@
// generic single-port ram with registered read
module ppu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                           wdata_i,
  output logic [Width-1:0]                           rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ hdl/ppu_div.sv @@
// restoring divider, one quotient bit per cycle, result capped at one in q16
module ppu_div import ppu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] rem_q, rem_d;
  logic [16:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic [47:0] num_q, num_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  assign trial = {rem_q[31:0], num_q[47]} - {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; rem_d = rem_q; quo_d = quo_q;
    den_d = den_q; num_d = num_q; done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1; cnt_d = 6'd0; rem_d = '0; quo_d = '0;
      den_d = req_i.divisor; num_d = {req_i.dividend, 16'd0};
    end else if (busy_q) begin
      // quotient only needs 17 bits once the high ones are cut, but every dividend bit is still stepped through
      num_d = {num_q[46:0], 1'b0};
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = (quo_q[16] || quo_q > {1'b0, 16'hffff}) ? OneQ16 : {quo_q[15:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], num_q[47]};
        quo_d = quo_q[16] ? OneQ16 : {quo_q[15:0], 1'b0};
      end
      if (!trial[32] && quo_q[16]) quo_d = OneQ16;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; num_q <= num_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.ratio = quo_q;
endmodule

@@ hdl/ppu_checker.sv @@
// port-level checks on the particle pool update block
`include "particle_pool_update_macros.svh"
module ppu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  `PPU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `PPU_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready, "ready stayed high after a transaction")
  `PPU_ASSERT(a_last_idle, clk_i, rst_ni, !(out_valid && !out_last && in_ready), "ready while a tick is still emitting")
endmodule

bind particle_pool_update ppu_checker u_ppu_checker (
  .clk_i, .rst_ni,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.data.last)
);
